FILE: design/zero_padded_2d_convolution_core_macros.svh
// ----------------------------------------------------------------------------
// zero_padded_2d_convolution_core_macros
// Assertion macros shared by the convolution core.
// ----------------------------------------------------------------------------
`ifndef ZERO_PADDED_2D_CONVOLUTION_CORE_MACROS_SVH
`define ZERO_PADDED_2D_CONVOLUTION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ZPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ZPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/zpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpc_pkg
// Shared constants and codes of the zero-padded 2D convolution core.
// ----------------------------------------------------------------------------
package zpc_pkg;

  // Default configuration of the core
  localparam int unsigned KERNEL_RADIUS = 2;
  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;

  // Port field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned COEF_IDX_W = 5;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned OROW_W     = 12;
  localparam int unsigned OCOL_W     = 10;
  localparam int unsigned WREG_W     = 11;
  localparam int unsigned HREG_W     = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // Register reset values
  localparam int unsigned WIDTH_RST  = 1024;
  localparam int unsigned HEIGHT_RST = 1024;

  // Saturation bound of the Q13.16 sum
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

endpackage

FILE: design/zero_padded_2d_convolution_core.sv
`timescale 1ns / 1ps
// An emitting word passes the input, product, row-sum and output registers.
// Throughput: one word per cycle unless stalled; the line store has one read
// and one write port. A flush of a frame whose last pixel comes before the first
// output position steps the window once per cycle until it is reached.
// Reset: counters clear, coefficients zero, width and height 1024; the line
// store is not cleared (its stale rows are masked by the frame borders).
// ----------------------------------------------------------------------------
// zero_padded_2d_convolution_core
// Square-kernel convolution over a raster stream with zero padding, using
// a column line store, a sliding window and a registered sum pipeline.
// ----------------------------------------------------------------------------
`include "zero_padded_2d_convolution_core_macros.svh"

module zero_padded_2d_convolution_core #(
  parameter int unsigned KERNEL_RADIUS = zpc_pkg::KERNEL_RADIUS,
  parameter int unsigned MAX_WIDTH     = zpc_pkg::MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [zpc_pkg::FUNC_W-1:0]      func_i,
  input  logic [zpc_pkg::COEF_IDX_W-1:0]  coef_index_i,
  input  logic [zpc_pkg::COEF_W-1:0]      coef_value_i,
  input  logic [zpc_pkg::PIX_W-1:0]       pixel_value_i,
  // output words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [zpc_pkg::SUM_W-1:0]       filtered_value_o,
  output logic [zpc_pkg::OROW_W-1:0]      out_row_o,
  output logic [zpc_pkg::OCOL_W-1:0]      out_col_o,
  output logic                            frame_last_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [zpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [zpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PIX_W   = zpc_pkg::PIX_W;
  localparam int unsigned COEF_W  = zpc_pkg::COEF_W;
  localparam int unsigned SUM_W   = zpc_pkg::SUM_W;
  localparam int unsigned OROW_W  = zpc_pkg::OROW_W;
  localparam int unsigned OCOL_W  = zpc_pkg::OCOL_W;
  localparam int unsigned WREG_W  = zpc_pkg::WREG_W;
  localparam int unsigned HREG_W  = zpc_pkg::HREG_W;
  localparam int unsigned MAX_HGT = zpc_pkg::MAX_HEIGHT;

  localparam int unsigned KDIM    = 2 * KERNEL_RADIUS + 1;
  localparam int unsigned NCOEF   = KDIM * KDIM;
  localparam int unsigned CI_W    = $clog2(NCOEF);
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W   = $clog2(MAX_HGT + 1);
  localparam int unsigned OR_W    = $clog2(MAX_HGT);
  localparam int unsigned ROW_W   = $clog2(MAX_HGT + 2 * KERNEL_RADIUS + 2);
  localparam int unsigned IDX_W   =
    $clog2(MAX_WIDTH * MAX_HGT + (KERNEL_RADIUS + 1) * MAX_WIDTH + 1);
  localparam int unsigned LB_W    = 2 * KERNEL_RADIUS * PIX_W;
  localparam int unsigned PROD_W  = PIX_W + COEF_W;
  localparam int unsigned RSUM_W  = PROD_W + $clog2(KDIM);
  localparam int unsigned TSUM_W  = RSUM_W + $clog2(KDIM);
  localparam int unsigned ACC_W   = (TSUM_W > SUM_W) ? TSUM_W : SUM_W;
  localparam int unsigned W_RST   =
    (zpc_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : zpc_pkg::WIDTH_RST;
  localparam int unsigned LAG_RST = KERNEL_RADIUS * W_RST + KERNEL_RADIUS;

  // --------------------------------------------------------------------------
  // Frame size registers
  // --------------------------------------------------------------------------
  logic [WID_W-1:0]  w_q, cfg_w;
  logic [HGT_W-1:0]  h_q, cfg_h;
  logic [IDX_W-1:0]  lag_q;
  logic [WREG_W-1:0] cfg_wv;
  logic [HREG_W-1:0] cfg_hv;
  logic              cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cfg_wv      = cfg_data_i[WREG_W-1:0];
  assign cfg_hv      = cfg_data_i[HREG_W-1:0];

  // clamp written sizes to the supported range
  always_comb begin
    if (cfg_wv == '0) begin
      cfg_w = WID_W'(1);
    end else if (32'(cfg_wv) > MAX_WIDTH) begin
      cfg_w = WID_W'(MAX_WIDTH);
    end else begin
      cfg_w = WID_W'(cfg_wv);
    end
    if (cfg_hv == '0) begin
      cfg_h = HGT_W'(1);
    end else if (32'(cfg_hv) > MAX_HGT) begin
      cfg_h = HGT_W'(MAX_HGT);
    end else begin
      cfg_h = HGT_W'(cfg_hv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= WID_W'(W_RST);
      h_q   <= HGT_W'(zpc_pkg::HEIGHT_RST);
      lag_q <= IDX_W'(LAG_RST);
    end else if (cfg_we) begin
      unique case (zpc_pkg::reg_e'(cfg_index_i))
        zpc_pkg::REG_WIDTH: begin
          w_q   <= cfg_w;
          lag_q <= IDX_W'(KERNEL_RADIUS) * IDX_W'(cfg_w) + IDX_W'(KERNEL_RADIUS);
        end
        zpc_pkg::REG_HEIGHT: begin
          h_q <= cfg_h;
        end
        default: begin
          h_q <= h_q;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic                          s1_v_q;
  logic [zpc_pkg::FUNC_W-1:0]    s1_func_q;
  logic [zpc_pkg::COEF_IDX_W-1:0] s1_cidx_q;
  logic [COEF_W-1:0]             s1_cval_q;
  logic [PIX_W-1:0]              s1_pix_q;

  // position of the window column and of the next output
  logic [COL_W-1:0] pos_col_q, pos_col_d;
  logic [ROW_W-1:0] pos_row_q, pos_row_d;
  logic [IDX_W-1:0] pos_idx_q, pos_idx_d;
  logic             in_done_q, in_done_d;
  logic [COL_W-1:0] o_col_q, o_col_d;
  logic [OR_W-1:0]  o_row_q, o_row_d;

  logic s1_pix_ok, s1_fl_ok, s1_shift, s1_emit, s1_keep, s1_go, s1_leave;
  logic s1_load, frame_last, frame_end, pos_last_col, o_last_col, in_acc;
  logic s2_free, s3_free, out_free;
  logic s2_v_q, s3_v_q, out_v_q;

  assign s1_pix_ok = s1_v_q && (s1_func_q == zpc_pkg::FUNC_PIXEL) && !in_done_q;
  assign s1_fl_ok  = s1_v_q && (s1_func_q == zpc_pkg::FUNC_FLUSH) && in_done_q;
  assign s1_shift  = s1_pix_ok || s1_fl_ok;
  assign s1_emit   = s1_shift && (pos_idx_q >= lag_q);
  // a flush short of the first output position steps without leaving
  assign s1_keep   = s1_fl_ok && !s1_emit;
  assign s1_load   = s1_v_q && (s1_func_q == zpc_pkg::FUNC_LOAD) &&
                     (32'(s1_cidx_q) < NCOEF);

  assign out_free  = !out_v_q || !out_stall_i;
  assign s3_free   = !s3_v_q || out_free;
  assign s2_free   = !s2_v_q || s3_free;
  assign s1_go     = s1_v_q && (!s1_emit || s2_free);
  assign s1_leave  = s1_go && !s1_keep;
  assign in_stall_o = s1_v_q && !s1_leave;
  assign in_acc    = in_valid_i && !in_stall_o;

  assign pos_last_col = WID_W'(pos_col_q) == (w_q - WID_W'(1));
  assign o_last_col   = WID_W'(o_col_q) == (w_q - WID_W'(1));
  assign frame_last   = o_last_col && (HGT_W'(o_row_q) == (h_q - HGT_W'(1)));
  assign frame_end    = s1_go && s1_emit && frame_last;

  // position counters: advance per step and output, rewind at end or on cfg write
  always_comb begin
    pos_col_d = pos_col_q;
    pos_row_d = pos_row_q;
    pos_idx_d = pos_idx_q;
    in_done_d = in_done_q;
    o_col_d   = o_col_q;
    o_row_d   = o_row_q;
    if (cfg_we || frame_end) begin
      pos_col_d = '0;
      pos_row_d = '0;
      pos_idx_d = '0;
      in_done_d = 1'b0;
      o_col_d   = '0;
      o_row_d   = '0;
    end else if (s1_go) begin
      if (s1_shift) begin
        pos_idx_d = pos_idx_q + IDX_W'(1);
        if (pos_last_col) begin
          pos_col_d = '0;
          pos_row_d = pos_row_q + ROW_W'(1);
        end else begin
          pos_col_d = pos_col_q + COL_W'(1);
        end
      end
      if (s1_pix_ok && pos_last_col &&
          (pos_row_q == ROW_W'(h_q - HGT_W'(1)))) begin
        in_done_d = 1'b1;
      end
      if (s1_emit) begin
        if (o_last_col) begin
          o_col_d = '0;
          o_row_d = o_row_q + OR_W'(1);
        end else begin
          o_col_d = o_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      pos_col_q <= '0;
      pos_row_q <= '0;
      pos_idx_q <= '0;
      in_done_q <= 1'b0;
      o_col_q   <= '0;
      o_row_q   <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_leave) begin
        s1_v_q <= 1'b0;
      end
      pos_col_q <= pos_col_d;
      pos_row_q <= pos_row_d;
      pos_idx_q <= pos_idx_d;
      in_done_q <= in_done_d;
      o_col_q   <= o_col_d;
      o_row_q   <= o_row_d;
    end
  end

  // input word payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= func_i;
      s1_cidx_q <= coef_index_i;
      s1_cval_q <= coef_value_i;
      s1_pix_q  <= pixel_value_i;
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient store
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0] coef_q [NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (s1_go && s1_load) begin
      coef_q[CI_W'(s1_cidx_q)] <= s1_cval_q;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one entry per column holding the 2R rows above
  // --------------------------------------------------------------------------
  logic [LB_W-1:0]  lb_mem [MAX_WIDTH];
  logic [LB_W-1:0]  lb_rd_q, byp_data_q, lb_rdata, lb_wdata;
  logic             byp_q, lb_we, lb_re;
  logic [PIX_W-1:0] new_pix;

  assign lb_we    = s1_go && s1_shift;
  assign lb_re    = in_acc || (s1_go && s1_keep);
  assign new_pix  = s1_pix_ok ? s1_pix_q : '0;
  assign lb_rdata = byp_q ? byp_data_q : lb_rd_q;
  assign lb_wdata = {lb_rdata[LB_W-PIX_W-1:0], new_pix};

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      lb_mem[pos_col_q] <= lb_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_re) begin
      lb_rd_q <= lb_mem[pos_col_d];
    end
  end

  // forward a same-column write that lands on the read edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (lb_re) begin
      byp_q <= lb_we && (pos_col_q == pos_col_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_re) begin
      byp_data_q <= lb_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Window: slot j holds the column j positions back, entry k is k rows up
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  win_q [KDIM][KDIM];
  logic [PIX_W-1:0]  win_d [KDIM][KDIM];
  logic [KDIM-1:0]   row_ok, col_ok;
  logic [PROD_W-1:0] prod_d [NCOEF];

  always_comb begin
    win_d[0][0] = new_pix;
    for (int k = 1; k < KDIM; k++) begin
      win_d[0][k] = lb_rdata[(k-1)*PIX_W +: PIX_W];
    end
    for (int j = 1; j < KDIM; j++) begin
      for (int k = 0; k < KDIM; k++) begin
        win_d[j][k] = win_q[j-1][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      win_q <= win_d;
    end
  end

  // border masks and products for the output at (o_row, o_col)
  always_comb begin
    for (int k = 0; k < KDIM; k++) begin
      row_ok[k] = (int'(o_row_q) + k >= KERNEL_RADIUS) &&
                  (int'(o_row_q) + k < int'(h_q) + KERNEL_RADIUS);
      col_ok[k] = (int'(o_col_q) + k >= KERNEL_RADIUS) &&
                  (int'(o_col_q) + k < int'(w_q) + KERNEL_RADIUS);
    end
    for (int ki = 0; ki < KDIM; ki++) begin
      for (int kj = 0; kj < KDIM; kj++) begin
        prod_d[ki*KDIM+kj] = (row_ok[ki] && col_ok[kj]) ?
          PROD_W'(win_d[KDIM-1-kj][KDIM-1-ki]) * PROD_W'(coef_q[ki*KDIM+kj]) : '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] s2_prod_q [NCOEF];
  logic [OR_W-1:0]   s2_row_q, s3_row_q, out_row_q;
  logic [COL_W-1:0]  s2_col_q, s3_col_q, out_col_q;
  logic              s2_last_q, s3_last_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_go && s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_prod_q <= prod_d;
      s2_row_q  <= o_row_q;
      s2_col_q  <= o_col_q;
      s2_last_q <= frame_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: kernel row sums
  // --------------------------------------------------------------------------
  logic [RSUM_W-1:0] rsum_d [KDIM];
  logic [RSUM_W-1:0] s3_rsum_q [KDIM];

  always_comb begin
    for (int ki = 0; ki < KDIM; ki++) begin
      rsum_d[ki] = '0;
      for (int kj = 0; kj < KDIM; kj++) begin
        rsum_d[ki] = rsum_d[ki] + RSUM_W'(s2_prod_q[ki*KDIM+kj]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free) begin
      s3_rsum_q <= rsum_d;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_last_q <= s2_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: total and saturation
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] tsum_d;
  logic [SUM_W-1:0] sat_d, out_val_q;

  always_comb begin
    tsum_d = '0;
    for (int ki = 0; ki < KDIM; ki++) begin
      tsum_d = tsum_d + ACC_W'(s3_rsum_q[ki]);
    end
    sat_d = (tsum_d > ACC_W'(zpc_pkg::SUM_MAX)) ? zpc_pkg::SUM_MAX : SUM_W'(tsum_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_val_q  <= sat_d;
      out_row_q  <= s3_row_q;
      out_col_q  <= s3_col_q;
      out_last_q <= s3_last_q;
    end
  end

  assign out_valid_o      = out_v_q;
  assign filtered_value_o = out_val_q;
  assign out_row_o        = OROW_W'(out_row_q);
  assign out_col_o        = OCOL_W'(out_col_q);
  assign frame_last_o     = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ZPC_ASSERT_NEXT(a_frame_rewind, frame_end,
    (pos_idx_q == '0) && !in_done_q && (o_col_q == '0) && (o_row_q == '0),
    "counters did not rewind after the last word of a frame")
  `ZPC_ASSERT_NOW(a_out_pos_in_frame, s1_v_q || !s1_v_q,
    (WID_W'(o_col_q) < w_q) && (HGT_W'(o_row_q) < h_q),
    "next output position lies outside the frame")
  `ZPC_ASSERT_NEXT(a_accept_lands, in_acc, s1_v_q,
    "accepted word did not reach the input register")

endmodule
